[rtl/core/multilevel_feedback_dispatcher_assert.svh]
// Assertion macros shared by the dispatcher modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MULTILEVEL_FEEDBACK_DISPATCHER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_DISPATCHER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher assertion failed");

`else

`define MFD_ASSERT_SAME(label, ante, cons)
`define MFD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[rtl/core/mfd_pkg.sv]
`default_nettype none

package mfd_pkg;

    // Field widths of the transactions.
    localparam int CMD_W    = 1;
    localparam int JOB_ID_W = 8;
    localparam int LEVEL_W  = 2;
    localparam int TICKS_W  = 16;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;
    localparam int REC_W    = JOB_ID_W + TICKS_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ARRIVE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RUN    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [JOB_ID_W-1:0] job_id;
        logic [LEVEL_W-1:0]  level;
        logic [TICKS_W-1:0]  service_ticks;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [JOB_ID_W-1:0] served_id;
        logic [LEVEL_W-1:0]  served_level;
        logic [LEVEL_W-1:0]  next_level;
        logic [TICKS_W-1:0]  ticks_left;
        logic [TIME_W-1:0]   now;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/mfd_in_if.sv]
`default_nettype none

interface mfd_in_if import mfd_pkg::*; ();

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/core/mfd_out_if.sv]
`default_nettype none

interface mfd_out_if import mfd_pkg::*; ();

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

[rtl/core/mfd_ram.sv]
`default_nettype none

module mfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/mfd_ctrl.sv]
`default_nettype none
`include "multilevel_feedback_dispatcher_assert.svh"

module mfd_ctrl import mfd_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    // Take a transaction in the idle state, complete it once the result slot is free.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MFD_ASSERT_NEXT(a_capture_to_exec, cmd.capture, state_reg == S_EXEC && !in_ready)
    `MFD_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_reg == S_IDLE)

endmodule

`default_nettype wire

[rtl/core/mfd_datapath.sv]
`default_nettype none
`include "multilevel_feedback_dispatcher_assert.svh"

module mfd_datapath import mfd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     st,
    input  wire in_item_t  item,
    mfd_out_if.source      response
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W     = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS) : 1;
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Per-level queue bookkeeping.
    logic [PTR_W-1:0]  head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]  tail_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] nonempty;
    logic [NUM_LEVELS-1:0] full;

    logic [TIME_W-1:0] time_reg;

    // Captured transaction.
    logic [CMD_W-1:0]    cmd_reg;
    logic [JOB_ID_W-1:0] id_reg;
    logic [TICKS_W-1:0]  svc_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [LVL_W-1:0]    tick_lvl_reg;
    logic                tick_idle_reg;

    // Result slot.
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Selection and job RAM signals.
    logic [LVL_W-1:0]  in_lvl_sat;
    logic [LVL_W-1:0]  sel_lvl;
    logic              sel_found;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [REC_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_rdata;

    // Serve step signals.
    logic [JOB_ID_W-1:0] rec_id;
    logic [TICKS_W-1:0]  rec_left;
    logic [LVL_W-1:0]    nx_base;
    logic [LVL_W-1:0]    nx_lvl;
    logic                push_en;
    logic [LVL_W-1:0]    push_lvl;
    logic                pop_en;
    logic [LVL_W-1:0]    pop_lvl;
    out_item_t           result;

    function automatic logic [ADDR_W-1:0] rec_addr(input logic [LVL_W-1:0] lv,
                                                   input logic [PTR_W-1:0] p);
        rec_addr = ADDR_W'(ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
    endfunction

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Empty and full flags of every level.
    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            nonempty[l] = (count_reg[l] != '0);
            full[l]     = (count_reg[l] == CNT_W'(QUEUE_DEPTH));
        end
    end

    // Arrival level saturates at the last level.
    assign in_lvl_sat = (int'(item.level) > NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1)
                                                             : LVL_W'(item.level);

    // Level to serve: real time first, then the highest non-empty level.
    always_comb
    begin
        sel_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 1; l--)
        begin
            if (nonempty[l])
            begin
                sel_lvl = LVL_W'(l);
            end
        end
        if (nonempty[0])
        begin
            sel_lvl = '0;
        end
    end

    assign sel_found = |nonempty;
    assign ram_raddr = rec_addr(sel_lvl, head_reg[sel_lvl]);

    mfd_ram #(
        .WIDTH (REC_W),
        .DEPTH (MEM_DEPTH)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Head record fields and the level below the one served.
    assign rec_id   = ram_rdata[REC_W-1:TICKS_W];
    assign rec_left = ram_rdata[TICKS_W-1:0] - TICKS_W'(1);
    assign nx_base  = (tick_lvl_reg == LVL_W'(NUM_LEVELS - 1)) ? tick_lvl_reg
                                                                : tick_lvl_reg + LVL_W'(1);
    assign nx_lvl   = full[nx_base] ? tick_lvl_reg : nx_base;

    // Work out the result and the queue updates of the captured transaction.
    always_comb
    begin
        ram_we              = 1'b0;
        ram_waddr           = rec_addr(lvl_reg, tail_reg[lvl_reg]);
        ram_wdata           = {id_reg, svc_reg};
        push_en             = 1'b0;
        push_lvl            = lvl_reg;
        pop_en              = 1'b0;
        pop_lvl             = tick_lvl_reg;
        result.status       = ST_IDLE;
        result.served_id    = '0;
        result.served_level = '0;
        result.next_level   = '0;
        result.ticks_left   = '0;
        result.now          = time_reg;
        if (cmd_reg == CMD_ARRIVE)
        begin
            result.served_id    = id_reg;
            result.served_level = LEVEL_W'(lvl_reg);
            result.next_level   = LEVEL_W'(lvl_reg);
            result.ticks_left   = svc_reg;
            if (svc_reg == '0)
            begin
                result.status = ST_ZERO;
            end
            else if (full[lvl_reg])
            begin
                result.status = ST_FULL;
            end
            else
            begin
                result.status = ST_ACCEPT;
                ram_we        = cmd.finish;
                push_en       = cmd.finish;
            end
        end
        else if (!tick_idle_reg)
        begin
            result.served_id    = rec_id;
            result.served_level = LEVEL_W'(tick_lvl_reg);
            if (rec_left == '0)
            begin
                // The job is done and leaves its queue.
                result.status = ST_DONE;
                pop_en        = cmd.finish;
            end
            else if (tick_lvl_reg == '0)
            begin
                // A real-time job keeps its place at the head.
                result.status     = ST_RUN;
                result.ticks_left = rec_left;
                ram_we            = cmd.finish;
                ram_waddr         = rec_addr(tick_lvl_reg, head_reg[tick_lvl_reg]);
                ram_wdata         = {rec_id, rec_left};
            end
            else
            begin
                // Move the job one level down, or back to its own tail.
                result.status     = ST_RUN;
                result.ticks_left = rec_left;
                result.next_level = LEVEL_W'(nx_lvl);
                pop_en            = cmd.finish;
                push_en           = cmd.finish;
                push_lvl          = nx_lvl;
                ram_we            = cmd.finish;
                ram_waddr         = rec_addr(nx_lvl, tail_reg[nx_lvl]);
                ram_wdata         = {rec_id, rec_left};
            end
        end
    end

    // Queue pointers, fill counts and the time counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            time_reg <= '0;
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                if (pop_en && pop_lvl == LVL_W'(l))
                begin
                    head_reg[l] <= bump(head_reg[l]);
                end
                if (push_en && push_lvl == LVL_W'(l))
                begin
                    tail_reg[l] <= bump(tail_reg[l]);
                end
                if (push_en && push_lvl == LVL_W'(l) && !(pop_en && pop_lvl == LVL_W'(l)))
                begin
                    count_reg[l] <= count_reg[l] + CNT_W'(1);
                end
                else if (pop_en && pop_lvl == LVL_W'(l) && !(push_en && push_lvl == LVL_W'(l)))
                begin
                    count_reg[l] <= count_reg[l] - CNT_W'(1);
                end
            end
            if (cmd.capture && item.command == CMD_TICK)
            begin
                time_reg <= time_reg + TIME_W'(1);
            end
        end
    end

    // Capture the accepted transaction and the level picked for service.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg       <= item.command;
            id_reg        <= item.job_id;
            svc_reg       <= item.service_ticks;
            lvl_reg       <= in_lvl_sat;
            tick_lvl_reg  <= sel_lvl;
            tick_idle_reg <= !sel_found;
        end
    end

    // Result slot: filled on completion, emptied when the transaction is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= result;
        end
    end

    assign st.out_free     = !out_valid_reg || response.ready;
    assign response.valid  = out_valid_reg;
    assign response.data   = out_data_reg;

    `MFD_ASSERT_SAME(a_finish_slot_free, cmd.finish, st.out_free)
    `MFD_ASSERT_SAME(a_pop_nonempty, pop_en, nonempty[pop_lvl])
    `MFD_ASSERT_SAME(a_push_room, push_en && !(pop_en && pop_lvl == push_lvl), !full[push_lvl])
    `MFD_ASSERT_NEXT(a_time_step, cmd.capture && item.command == CMD_TICK, time_reg == $past(time_reg) + TIME_W'(1))

endmodule

`default_nettype wire

[rtl/core/multilevel_feedback_dispatcher.sv]
// Multilevel feedback dispatcher. Each transaction on the request channel is either an arrival,
// which places a job at its priority level or rejects it, or a tick, which advances the time
// counter and serves one unit of work; every request yields exactly one response transaction.
// Job records live in one RAM holding NUM_LEVELS queues of QUEUE_DEPTH entries each. When a
// request is accepted, the head record of the level to serve is read from the job RAM; in the
// execute state, once the output register is free, the record is updated or moved to another
// queue through the single write port while the result is loaded into the output register. A new
// request can be accepted while a finished response still waits to be taken; the block waits in
// its execute state only if the previous response has not left the output register. The job RAM
// needs no clearing after reset, so requests are taken as soon as reset is released.
`default_nettype none

module multilevel_feedback_dispatcher import mfd_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 4
) (
    input wire logic clk,
    input wire logic rst_n,
    mfd_in_if.sink   request,
    mfd_out_if.source response
);

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       ready;

    // Sequencing of each transaction.
    mfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (ready),
        .st       (st),
        .cmd      (cmd)
    );

    assign request.ready = ready;

    // Queues, job RAM, time counter and result register.
    mfd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .item     (request.data),
        .response (response)
    );

endmodule

`default_nettype wire
